// ===== src/wnafr_pkg.sv =====
// Shared types and constants for the wNAF scalar recoder.
`timescale 1ns / 1ps
package wnafr_pkg;

  localparam int unsigned DEF_SCALAR_BYTES = 32;
  localparam int unsigned QUEUE_DEPTH      = 2;
  localparam int unsigned MAX_RESULTS      = 17;
  localparam int unsigned CFG_IDX_W        = 2;

  localparam logic [2:0] RST_WINDOW_WIDTH = 3'd4;
  localparam logic [8:0] RST_DIGIT_BITS   = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_WIDTH = 2'd0,
    CFG_DIGIT_BITS   = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0] window_width;
    logic [8:0] digit_bits;
  } wnafr_cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } wnafr_item_t;

endpackage

// ===== src/wnafr_front.sv =====
// Front end: configuration registers, input acceptance and byte tagging.
`timescale 1ns / 1ps
module wnafr_front import wnafr_pkg::*; #(
  parameter int unsigned SCALAR_BYTES = DEF_SCALAR_BYTES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [8:0]           cfg_data_i,
  output wnafr_cfg_t           cfg_o,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           scalar_byte_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output wnafr_item_t          item_o
);

  localparam int unsigned CNT_W = $clog2(SCALAR_BYTES);
  localparam logic [CNT_W-1:0] LAST_BYTE = CNT_W'(SCALAR_BYTES - 1);

  wnafr_cfg_t       cfg_q, cfg_d;
  logic [CNT_W-1:0] byte_cnt_q, byte_cnt_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_WINDOW_WIDTH: cfg_d.window_width = cfg_data_i[2:0];
        CFG_DIGIT_BITS:   cfg_d.digit_bits   = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  assign item_o.data  = scalar_byte_i;
  assign item_o.first = (byte_cnt_q == '0);
  assign item_o.last  = (byte_cnt_q == LAST_BYTE);

  // wrap the byte count after the last byte of a scalar
  always_comb begin
    byte_cnt_d = byte_cnt_q;
    if (push_o) begin
      byte_cnt_d = item_o.last ? '0 : byte_cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_width <= RST_WINDOW_WIDTH;
      cfg_q.digit_bits   <= RST_DIGIT_BITS;
      byte_cnt_q         <= '0;
    end else begin
      cfg_q      <= cfg_d;
      byte_cnt_q <= byte_cnt_d;
    end
  end

endmodule

// ===== src/wnafr_queue.sv =====
// Short request queue between the front end and the digit sequencer.
`timescale 1ns / 1ps
module wnafr_queue import wnafr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  wnafr_item_t item_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        valid_o,
  output wnafr_item_t item_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  wnafr_item_t      entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

// ===== src/wnafr_back.sv =====
// Back end: bit-serial window sequencer that emits at most one wNAF digit per cycle, held by output stalls.
`timescale 1ns / 1ps
module wnafr_back import wnafr_pkg::*; #(
  parameter int unsigned SCALAR_BYTES = DEF_SCALAR_BYTES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wnafr_cfg_t        cfg_i,
  input  logic              q_valid_i,
  input  wnafr_item_t       q_item_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic signed [7:0] naf_digit_o,
  output logic [8:0]        digit_index_o,
  output logic              last_digit_o
);

  localparam int unsigned SCALAR_BITS = 8 * SCALAR_BYTES;
  localparam logic [9:0]  BITS_LIM    = 10'(SCALAR_BITS);
  localparam int unsigned RES_W       = $clog2(MAX_RESULTS + 1);
  localparam logic [RES_W-1:0] RES_CAP = RES_W'(MAX_RESULTS);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_BITS  = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [7:0]       bits_q, bits_d;
  logic             first_q, first_d;
  logic             last_q, last_d;
  logic [2:0]       cnt_q, cnt_d;
  logic [RES_W-1:0] res_q, res_d;
  logic [8:0]       win_q, win_d;
  logic [9:0]       idx_q, idx_d;

  logic             out_valid_q, out_valid_d;
  logic [7:0]       digit_q;
  logic [8:0]       index_q;
  logic             last_dig_q;

  logic [2:0]       eff_w;
  logic [9:0]       eff_bits;
  logic [8:0]       bitw;
  logic [9:0]       nb;
  logic             done;
  logic             near_top;
  logic [9:0]       dig;
  logic [9:0]       win_sub;
  logic [8:0]       win_nxt;
  logic             cur_bit;
  logic             fill;
  logic             can_emit;
  logic             slot_free;
  logic             emit;
  logic             advance;

  assign eff_w    = (cfg_i.window_width == 3'd0) ? 3'd1 : cfg_i.window_width;
  assign eff_bits = ({1'b0, cfg_i.digit_bits} > BITS_LIM) ? BITS_LIM
                                                          : {1'b0, cfg_i.digit_bits};
  assign bitw     = 9'd1 << eff_w;
  assign nb       = {1'b0, bitw} << 1;
  assign done     = (idx_q > eff_bits);
  assign near_top = (11'(idx_q) + 11'(eff_w) + 11'd1) >= 11'(eff_bits);

  // digit from the current window
  always_comb begin
    dig = '0;
    if (win_q[0]) begin
      if (|(win_q & bitw)) begin
        if (near_top) begin
          dig = {1'b0, win_q & (bitw - 9'd1)};
        end else begin
          dig = {1'b0, win_q} - nb;
        end
      end else begin
        dig = {1'b0, win_q};
      end
    end
  end

  assign win_sub = {1'b0, win_q} - dig;
  assign cur_bit = (state_q == ST_FLUSH) ? 1'b0 : bits_q[cnt_q];
  assign win_nxt = win_sub[9:1] + (cur_bit ? bitw : 9'd0);

  assign fill      = (idx_q == '0) && first_q && (cnt_q <= eff_w);
  assign can_emit  = !done && (res_q < RES_CAP);
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    bits_d  = bits_q;
    first_d = first_q;
    last_d  = last_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    win_d   = win_q;
    idx_d   = idx_q;
    q_pop_o = 1'b0;
    emit    = 1'b0;
    advance = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          bits_d  = q_item_i.data;
          first_d = q_item_i.first;
          last_d  = q_item_i.last;
          cnt_d   = '0;
          res_d   = '0;
          state_d = ST_BITS;
        end
      end
      ST_BITS: begin
        if (fill) begin
          win_d   = win_q | (9'(cur_bit) << cnt_q);
          advance = 1'b1;
        end else if (can_emit) begin
          // hold the bit while the output register is occupied
          emit    = slot_free;
          advance = slot_free;
        end else begin
          advance = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (can_emit) begin
          emit = slot_free;
        end else begin
          win_d   = '0;
          idx_d   = '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (emit) begin
      win_d = win_nxt;
      idx_d = idx_q + 10'd1;
      res_d = res_q + RES_W'(1);
    end

    if (advance) begin
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        state_d = last_q ? ST_FLUSH : ST_IDLE;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q  <= bits_d;
    first_q <= first_d;
    last_q  <= last_d;
    cnt_q   <= cnt_d;
    res_q   <= res_d;
    if (emit) begin
      digit_q    <= dig[7:0];
      index_q    <= idx_q[8:0];
      last_dig_q <= (idx_q == eff_bits);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_q       <= win_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign naf_digit_o   = digit_q;
  assign digit_index_o = index_q;
  assign last_digit_o  = last_dig_q;

endmodule

// ===== src/wnaf_scalar_recoder_unit.sv =====
// Top level of the width-w NAF scalar recoder.
//
// Scalar bytes enter on the in channel (valid/ready), least significant byte
// first, SCALAR_BYTES bytes per scalar. Signed digits for indices 0..digit_bits,
// capped at 8*SCALAR_BYTES, leave on the out channel (valid/ready) with their
// index; last_digit_o marks the final digit of a scalar. window_width (index 0)
// and digit_bits (index 1) are written over the cfg channel, which is always
// ready; write them only while no request is in flight.
// A two-entry queue sits between the input side and the digit sequencer, so
// bytes keep being accepted while the sequencer works or the output stalls.
// The sequencer handles one scalar bit per cycle unless a stalled output holds
// it: a byte takes one load step plus eight bit steps, and the last byte of a
// scalar adds one flush step per remaining digit and a step that clears the window.
// With the sequencer idle, an accepted byte is registered in the queue and then
// in the sequencer before out_valid_o rises; on the first byte of a scalar the
// low w+1 bits only fill the window, so its first digit comes later than that.
// A stalled receiver holds the output register; the sequencer then holds the
// bit that wants to emit, and the queue fills before in_ready_o drops.
// Reset restores window_width 4 and digit_bits 256 and empties the block.
`timescale 1ns / 1ps
module wnaf_scalar_recoder_unit import wnafr_pkg::*; #(
  parameter int unsigned SCALAR_BYTES = DEF_SCALAR_BYTES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [8:0]           cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           scalar_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [7:0]    naf_digit_o,
  output logic [8:0]           digit_index_o,
  output logic                 last_digit_o
);

  localparam logic [8:0] BITS_LIM = 9'(8 * SCALAR_BYTES);

  wnafr_cfg_t  cfg;
  wnafr_item_t push_item;
  wnafr_item_t pop_item;
  logic        push;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;

  wnafr_front #(
    .SCALAR_BYTES(SCALAR_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cfg_o        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .scalar_byte_i(scalar_byte_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .item_o       (push_item)
  );

  wnafr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .item_o (pop_item)
  );

  wnafr_back #(
    .SCALAR_BYTES(SCALAR_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .q_valid_i    (q_valid),
    .q_item_i     (pop_item),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .naf_digit_o  (naf_digit_o),
    .digit_index_o(digit_index_o),
    .last_digit_o (last_digit_o)
  );

  // digits are zero or odd
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (naf_digit_o[0] || (naf_digit_o == 8'sd0)))
    else $error("even nonzero wNAF digit");

  // the end flag sits on the configured (clamped) last index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_digit_o) |->
      ((digit_index_o == cfg.digit_bits) || (digit_index_o == BITS_LIM)))
    else $error("last digit flag on wrong index");

  // the sequencer never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty request queue");

  // a full queue refuses new requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> (!in_ready_o && !push))
    else $error("request taken while queue full");

endmodule

// ===== tb/tb_wnaf_scalar_recoder_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the wNAF scalar recoder: directed table, then random phases.
module tb_wnaf_scalar_recoder_unit;
  import wnafr_pkg::*;

  localparam int unsigned SETTLE_CYCLES   = 64;
  localparam int unsigned CYCLE_LIMIT     = 300000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam int unsigned SCALAR_BITS     = 8 * DEF_SCALAR_BYTES;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
  localparam int NUM_ROWS    = 18;
  localparam int NUM_PHASES  = 8;
  localparam int PICK_RANDOM = -1;
  localparam int REST_OF_SCALAR = 0;

  typedef struct packed {
    logic signed [7:0] digit;
    logic [8:0]        index;
    logic              last;
  } naf_digit_t;

  typedef enum logic { ROW_BYTE, ROW_REG } row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [8:0]            value;
    logic                  has_lit;
    naf_digit_t            lit;
  } stim_row_t;

  typedef enum int { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_mode_e;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [8:0]           cfg_data_i    = '0;
  logic                 in_valid_i    = 1'b0;
  logic [7:0]           scalar_byte_i = '0;
  logic                 out_ready_i   = 1'b0;
  logic                 cfg_ready_o;
  logic                 in_ready_o;
  logic                 out_valid_o;
  logic signed [7:0]    naf_digit_o;
  logic [8:0]           digit_index_o;
  logic                 last_digit_o;

  // Byte rows carry the byte in value; reg_idx is unused on them.
  stim_row_t stim_table [NUM_ROWS] = '{
    '{ROW_BYTE, '0, 9'h000, 1'b1, '{8'sd0, 9'd0, 1'b0}}, // zero low byte: first digit zero
    '{ROW_BYTE, '0, 9'h0FF, 1'b0, '0},
    '{ROW_BYTE, '0, 9'h080, 1'b0, '0},
    '{ROW_BYTE, '0, 9'h001, 1'b0, '0},
    '{ROW_REG, CFG_WINDOW_WIDTH, 9'd7, 1'b0, '0},        // widest window, mid-scalar
    '{ROW_BYTE, '0, 9'h0FF, 1'b0, '0},
    '{ROW_BYTE, '0, 9'h07F, 1'b0, '0},
    '{ROW_REG, CFG_WINDOW_WIDTH, 9'd0, 1'b0, '0},        // zero width acts as one
    '{ROW_BYTE, '0, 9'h055, 1'b0, '0},
    '{ROW_BYTE, '0, 9'h0AA, 1'b0, '0},
    '{ROW_REG, CFG_DIGIT_BITS, 9'd300, 1'b0, '0},        // clamps to the scalar length
    '{ROW_BYTE, '0, 9'h0FE, 1'b0, '0},
    '{ROW_REG, CFG_SPARE_IDX, 9'h1FF, 1'b0, '0},         // unmapped index, ignored
    '{ROW_BYTE, '0, 9'h001, 1'b0, '0},
    '{ROW_REG, CFG_WINDOW_WIDTH, 9'd3, 1'b0, '0},
    '{ROW_REG, CFG_DIGIT_BITS, 9'd9, 1'b0, '0},          // digits already past the end
    '{ROW_BYTE, '0, 9'h0FF, 1'b0, '0},
    '{ROW_BYTE, '0, 9'h000, 1'b0, '0}
  };

  // Phase 0 finishes the scalar left open above with a long index lag,
  // so its last byte runs into the per-byte result cap.
  int phase_ww [NUM_PHASES]  = '{7, 0, 1, 5, PICK_RANDOM, PICK_RANDOM, 2, 4};
  int phase_db [NUM_PHASES]  = '{256, 0, 511, PICK_RANDOM, 256, PICK_RANDOM, PICK_RANDOM, 256};
  int phase_len [NUM_PHASES] = '{REST_OF_SCALAR, 32, 16, 16, 32, 8, 24, 32};
  idle_mode_e phase_idle [NUM_PHASES] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
                                          IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};

  logic [2:0]  pred_ww;
  logic [8:0]  pred_db;
  logic [8:0]  pred_window;
  int unsigned pred_taken;
  int unsigned pred_next_idx;
  naf_digit_t  expected_digits [$];

  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;

  wnaf_scalar_recoder_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .scalar_byte_i (scalar_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .naf_digit_o   (naf_digit_o),
    .digit_index_o (digit_index_o),
    .last_digit_o  (last_digit_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic int unsigned width_in_use();
    return (pred_ww == 3'd0) ? 1 : int'(pred_ww);
  endfunction

  function automatic int unsigned length_in_use();
    return (pred_db > SCALAR_BITS) ? SCALAR_BITS : int'(pred_db);
  endfunction

  task automatic clear_scalar_state();
    pred_window   = '0;
    pred_taken    = 0;
    pred_next_idx = 0;
  endtask

  // Emit the digit at the current index, then shift the window and feed bit_in.
  task automatic shift_out_digit(input logic bit_in, inout int unsigned n_out);
    int unsigned w;
    int unsigned bits;
    int unsigned j;
    int bitw;
    int win;
    int d;
    w    = width_in_use();
    bits = length_in_use();
    j    = pred_next_idx;
    bitw = 1 << w;
    win  = int'(pred_window);
    d    = 0;
    if ((win & 1) != 0) begin
      if ((win & bitw) != 0) begin
        // near the top keep the digit positive so no carry is left over
        if (j + w + 1 >= bits) d = win & (bitw - 1);
        else d = win - (bitw << 1);
      end else begin
        d = win;
      end
      win = win - d;
    end
    win = win >>> 1;
    if (bit_in) win = win + bitw;
    pred_window = win[8:0];
    if (n_out < MAX_RESULTS) begin
      expected_digits.push_back('{digit: d[7:0], index: j[8:0], last: (j == bits)});
      n_out++;
    end
    pred_next_idx = (j + 1) & 32'h3FF;
  endtask

  task automatic predict_byte(input logic [7:0] b);
    int unsigned base;
    int unsigned pos;
    int unsigned n_out;
    n_out = 0;
    base  = 8 * pred_taken;
    for (int k = 0; k < 8; k++) begin
      pos = base + k;
      if (pred_next_idx == 0 && pos <= width_in_use()) begin
        pred_window = pred_window | (9'(b[k]) << pos);
      end else if (pred_next_idx <= length_in_use() && n_out < MAX_RESULTS) begin
        shift_out_digit(b[k], n_out);
      end
    end
    pred_taken++;
    if (pred_taken >= DEF_SCALAR_BYTES) begin
      // flush the remaining digits with zero bits, then start a fresh scalar
      while (pred_next_idx <= length_in_use() && n_out < MAX_RESULTS)
        shift_out_digit(1'b0, n_out);
      clear_scalar_state();
    end
  endtask

  // Entered and left at a falling edge; valid stays high for a following request.
  task automatic send_scalar_byte(input logic [7:0] b, input logic has_lit,
                                  input naf_digit_t lit);
    int unsigned first;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    scalar_byte_i = b;
    do @(posedge clk_i); while (!in_ready_o);
    first = expected_digits.size();
    predict_byte(b);
    if (has_lit && expected_digits.size() > first) expected_digits[first] = lit;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [8:0] value);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_WINDOW_WIDTH) pred_ww = value[2:0];
    else if (idx == CFG_DIGIT_BITS) pred_db = value;
    @(negedge clk_i);
  endtask

  // Drop both request lines, drain expected digits, then let silent bytes finish.
  task automatic settle_block();
    in_valid_i  = 1'b0;
    cfg_valid_i = 1'b0;
    while (expected_digits.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    naf_digit_t got;
    naf_digit_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{naf_digit_o, digit_index_o, last_digit_o};
      if (expected_digits.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected digit %0d index %0d last %0b",
                   got.digit, got.index, got.last);
      end else begin
        want = expected_digits.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("digit mismatch: expected %0d index %0d last %0b, got %0d index %0d last %0b",
                     want.digit, want.index, want.last, got.digit, got.index, got.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_wnaf_scalar_recoder_unit: errors");
      $finish;
    end
  end

  initial begin
    int unsigned n_bytes;
    logic [2:0]  ww;
    logic [8:0]  db;
    pred_ww = RST_WINDOW_WIDTH;
    pred_db = RST_DIGIT_BITS;
    clear_scalar_state();
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (stim_table[r]) begin
      if (stim_table[r].kind == ROW_REG) begin
        settle_block();
        write_reg(stim_table[r].reg_idx, stim_table[r].value);
        cfg_valid_i = 1'b0;
      end else begin
        send_scalar_byte(stim_table[r].value[7:0], stim_table[r].has_lit, stim_table[r].lit);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      ww = (phase_ww[p] == PICK_RANDOM) ? 3'($urandom_range(0, 7)) : 3'(phase_ww[p]);
      db = (phase_db[p] == PICK_RANDOM) ? 9'($urandom_range(0, 511)) : 9'(phase_db[p]);
      n_bytes = (phase_len[p] == REST_OF_SCALAR) ? DEF_SCALAR_BYTES - pred_taken
                                                 : phase_len[p];
      settle_block();
      write_reg(CFG_WINDOW_WIDTH, 9'(ww));
      write_reg(CFG_DIGIT_BITS, db);
      cfg_valid_i = 1'b0;
      send_idle_pct  = (phase_idle[p] == IDLE_SENDER) ? 58 :
                       (phase_idle[p] == IDLE_BOTH) ? 21 : 0;
      recv_stall_pct = (phase_idle[p] == IDLE_RECEIVER) ? 58 :
                       (phase_idle[p] == IDLE_BOTH) ? 21 : 0;
      // hold the output off while bytes keep coming, so the input backs up
      if (p == NUM_PHASES - 1) hold_left = HOLD_OFF_CYCLES;
      repeat (n_bytes) send_scalar_byte(8'($urandom_range(0, 255)), 1'b0, '0);
    end

    settle_block();
    if (mismatches == 0) begin
      $display("tb_wnaf_scalar_recoder_unit: clean");
    end else begin
      $display("tb_wnaf_scalar_recoder_unit: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/wnafr_pkg.sv
src/wnafr_front.sv
src/wnafr_queue.sv
src/wnafr_back.sv
src/wnaf_scalar_recoder_unit.sv
tb/tb_wnaf_scalar_recoder_unit.sv
